>>> src/bhpq_pkg.sv
// Package for the binary min-heap priority queue.
// Holds the command and result beat types and the operation and status codes.
// Depends on nothing.
`default_nettype none

package bhpq_pkg;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] entry_key;
        logic [15:0] entry_payload;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_key;
        logic [15:0] out_payload;
        logic [10:0] entries;
    } result_t;

endpackage

`default_nettype wire

>>> src/bhpq_store.sv
// Entry store of the heap: one write port and two read ports, read data registered.
// Standalone; used by the top level.
`default_nettype none

module bhpq_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int EW    = 32
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [EW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_a_addr,
    input  wire logic [AW-1:0] rd_b_addr,
    output logic      [EW-1:0] rd_a_data,
    output logic      [EW-1:0] rd_b_data
);

    logic [EW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

>>> src/bhpq_ctrl.sv
// Sequencer of the heap: sift up on insert, sift down on remove, one level a cycle.
// Depends on bhpq_pkg; drives the ports of bhpq_store.
`default_nettype none

module bhpq_ctrl
    import bhpq_pkg::*;
#(
    parameter int CAPACITY     = 1024,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16,
    parameter int AW           = 10,
    parameter int CW           = 11,
    parameter int EW           = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire cmd_t          cmd,
    output logic               done,
    output result_t            result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_data,
    output logic               wr_en,
    output logic      [AW-1:0] wr_addr,
    output logic      [EW-1:0] wr_data,
    output logic      [AW-1:0] rd_a_addr,
    output logic      [AW-1:0] rd_b_addr,
    input  wire logic [EW-1:0] rd_a_data,
    input  wire logic [EW-1:0] rd_b_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_ROOT,
        S_DOWN,
        S_FIN
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [EW-1:0]         cur_reg, cur_next;
    logic [KEY_BITS-1:0]   okey_reg, okey_next;
    logic [PAYLOAD_BITS-1:0] opay_reg, opay_next;
    logic                  ins_reg, ins_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  key_signed_reg, key_signed_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;

    logic [AW-1:0]         par_w;
    logic [AW+1:0]         l_ix;
    logic [AW+1:0]         r_ix;
    logic [AW+1:0]         nl_ix;
    logic [AW-1:0]         c_ix;
    logic                  take_r;
    logic [EW-1:0]         child;
    logic [CW-1:0]         n_left;

    function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                      input logic [KEY_BITS-1:0] b,
                                      input logic sgn);
        logic [KEY_BITS-1:0] fa;
        logic [KEY_BITS-1:0] fb;
        fa = a;
        fb = b;
        fa[KEY_BITS-1] = a[KEY_BITS-1] ^ sgn;
        fb[KEY_BITS-1] = b[KEY_BITS-1] ^ sgn;
        return fa < fb;
    endfunction

    function automatic logic [KEY_BITS-1:0] key_of(input logic [EW-1:0] e);
        return e[EW-1 -: KEY_BITS];
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        okey_next       = okey_reg;
        opay_next       = opay_reg;
        ins_next        = ins_reg;
        count_next      = count_reg;
        key_signed_next = key_signed_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = cur_reg;
        rd_a_addr       = '0;
        rd_b_addr       = '0;

        par_w  = (pos_reg - AW'(1)) >> 1;
        l_ix   = {1'b0, pos_reg, 1'b1};
        r_ix   = l_ix + (AW+2)'(1);
        take_r = (r_ix < (AW+2)'(count_reg))
                 && key_less(key_of(rd_b_data), key_of(rd_a_data), key_signed_reg);
        child  = take_r ? rd_b_data : rd_a_data;
        c_ix   = take_r ? AW'(r_ix) : AW'(l_ix);
        nl_ix  = {1'b0, c_ix, 1'b1};
        n_left = count_reg - CW'(1);

        if (cfg_valid && cfg_ready)
        begin
            key_signed_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ins_next  = (cmd.kind == KIND_INSERT);
                    okey_next = '0;
                    opay_next = '0;
                    if (cmd.kind == KIND_INSERT)
                    begin
                        cur_next = {KEY_BITS'(cmd.entry_key), PAYLOAD_BITS'(cmd.entry_payload)};
                        pos_next = AW'(count_reg);
                        if (count_reg == CW'(CAPACITY))
                        begin
                            done_next   = 1'b1;
                            result_next = '{STATUS_FULL, 16'd0, 16'd0, 11'(count_reg)};
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            rd_a_addr  = (AW'(count_reg) - AW'(1)) >> 1;
                            state_next = S_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            result_next = '{STATUS_EMPTY, 16'd0, 16'd0, 11'(count_reg)};
                        end
                        else
                        begin
                            rd_a_addr  = '0;
                            rd_b_addr  = AW'(n_left);
                            state_next = S_ROOT;
                        end
                    end
                end
            end

            S_UP:
            begin
                if (key_less(key_of(cur_reg), key_of(rd_a_data), key_signed_reg))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg;
                    wr_data  = rd_a_data;
                    pos_next = par_w;
                    if (par_w == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rd_a_addr = (par_w - AW'(1)) >> 1;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_ROOT:
            begin
                okey_next  = key_of(rd_a_data);
                opay_next  = rd_a_data[PAYLOAD_BITS-1:0];
                cur_next   = rd_b_data;
                count_next = n_left;
                pos_next   = '0;
                if (n_left > CW'(1))
                begin
                    rd_a_addr  = AW'(1);
                    rd_b_addr  = AW'(2);
                    state_next = S_DOWN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_DOWN:
            begin
                if (key_less(key_of(cur_reg), key_of(child), key_signed_reg))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg;
                    wr_data  = child;
                    pos_next = c_ix;
                    if (nl_ix < (AW+2)'(count_reg))
                    begin
                        rd_a_addr = AW'(nl_ix);
                        rd_b_addr = AW'(nl_ix + (AW+2)'(1));
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = cur_reg;
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (ins_reg)
                begin
                    count_next = count_reg + CW'(1);
                end
                result_next = '{STATUS_DONE, 16'(okey_reg), 16'(opay_reg), 11'(count_next)};
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            cur_reg        <= '0;
            okey_reg       <= '0;
            opay_reg       <= '0;
            ins_reg        <= 1'b0;
            count_reg      <= '0;
            key_signed_reg <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cur_reg        <= cur_next;
            okey_reg       <= okey_next;
            opay_reg       <= opay_next;
            ins_reg        <= ins_next;
            count_reg      <= count_next;
            key_signed_reg <= key_signed_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
        end
    end

endmodule

`default_nettype wire

>>> src/binary_min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue.
// Depends on bhpq_pkg and instantiates bhpq_ctrl and bhpq_store.
//
// A command beat (cmd: kind, entry_key, entry_payload) is taken at a rising
// edge with start high and busy low. Each command gives exactly one result
// beat on result, marked by done for a single cycle; the receiver cannot
// stall it, and the next command may be taken in the cycle that shows it.
// The result reports the status, the removed key and payload (zero for
// inserts and failures) and the number of entries held afterwards.
// An insert climbs through S_UP one level at a time and writes the entry in
// S_FIN; a remove reads the root and last entry in S_ROOT, sinks through
// S_DOWN one level at a time and writes in S_FIN. A full or empty refusal
// is answered in the cycle after it is taken. Each level takes one store access and compare.
// The cfg channel writes key_signed (1 for two's complement keys) and is
// ready only while the block is idle. Reset empties the queue and clears
// key_signed; the entry store needs no clearing.
`default_nettype none

module binary_min_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int CAPACITY     = 1024,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      done,
    output result_t   result,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic [EW-1:0] rd_a_data;
    logic [EW-1:0] rd_b_data;

    bhpq_ctrl #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW),
        .CW           (CW),
        .EW           (EW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    bhpq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .EW    (EW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

endmodule

`default_nettype wire
